// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine.
// Every macro samples on the rising edge of clk and is quiet while arst_n
// is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define PLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition at one edge that implies another at the next edge.
`define PLE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int POS_W          = 7;
	localparam int IO_DATA_W      = 32;
	localparam int WIDE_W         = 64;
	// Cells chained combinationally between two registers of the read chain.
	localparam int READ_GROUP     = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PLACE_POS   = 2'd0,
		PLACE_FRONT = 2'd1,
		PLACE_BACK  = 2'd2
	} place_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Shift commands broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One slot of the list with its shift logic and one link of the read chain.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int XW         = POS_W,
	parameter int IDX        = 0,
	parameter bit LINK_REG   = 1'b0
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [XW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] slot,
	input  logic [DATA_WIDTH-1:0] link_in,
	output logic [DATA_WIDTH-1:0] link_out
);

	localparam logic [XW-1:0] IDX_X = XW'(IDX);

	logic [DATA_WIDTH-1:0] slot_q;
	logic [DATA_WIDTH-1:0] link_d;
	logic                  hit;
	logic                  above;

	assign hit   = (pos == IDX_X);
	assign above = (IDX_X > pos);
	assign slot  = slot_q;

	// An insert moves the entries above the target up; a remove pulls the
	// entries at and above the target down.
	always_ff @(posedge clk) begin
		if (ctrl.ins && above) begin
			slot_q <= left;
		end else if (ctrl.ins && hit) begin
			slot_q <= din;
		end else if (ctrl.rem && (above || hit)) begin
			slot_q <= right;
		end
	end

	assign link_d = hit ? slot_q : link_in;

	generate
		if (LINK_REG) begin : g_reg
			logic [DATA_WIDTH-1:0] link_q;
			always_ff @(posedge clk) begin
				link_q <= link_d;
			end
			assign link_out = link_q;
		end else begin : g_comb
			assign link_out = link_d;
		end
	endgenerate

endmodule

// ===== rtl/core/ple_chain.sv =====
// ----------------------------------------------------------------------------
// ple_chain
// The row of list cells, neighbor to neighbor, with the read chain through it.
// ----------------------------------------------------------------------------
module ple_chain import ple_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int XW         = POS_W
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [XW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] din,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] slot_w [DEPTH];
	logic [DATA_WIDTH-1:0] link_w [DEPTH+1];

	assign link_w[0] = '0;
	assign rd_data   = link_w[DEPTH];

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			localparam bit LREG = ((i % READ_GROUP) == (READ_GROUP - 1)) || (i == DEPTH - 1);
			logic [DATA_WIDTH-1:0] left_w;
			logic [DATA_WIDTH-1:0] right_w;

			if (i == 0) begin : g_first
				assign left_w = slot_w[0];
			end else begin : g_left
				assign left_w = slot_w[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign right_w = slot_w[DEPTH-1];
			end else begin : g_right
				assign right_w = slot_w[i+1];
			end

			ple_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.XW         (XW),
				.IDX        (i),
				.LINK_REG   (LREG)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.pos      (pos),
				.din      (din),
				.left     (left_w),
				.right    (right_w),
				.slot     (slot_w[i]),
				.link_in  (link_w[i]),
				.link_out (link_w[i+1])
			);
		end
	endgenerate

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of up to DEPTH words with insert, remove, read and clear.
// ----------------------------------------------------------------------------
// Usage. Requests enter on in_valid/in_stall carrying op, place, position
// and data_in; a request is taken at a rising edge with in_valid high and
// in_stall low. Every request yields exactly one result on out_valid/
// out_stall carrying status, read_data, entry_count and is_empty.
// Request flow. For insert, remove, clear and every failed request the
// result is registered at the edge that takes the request, and the next
// request may follow in the very next cycle unless out_stall holds it.
// A successful read waits for the read chain, which runs through the row
// of cells with a register after every eight cells and after the last;
// in_stall stays high until its result is loaded.
// Reset. arst_n clears the entry count, the controller and the output
// valid flag; the slot contents are left as they are and are only read
// after they have been written.
// Stall. While a result waits with out_stall high, the output register
// holds it and in_stall is raised, so no request is lost or overtaken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine_core import ple_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [1:0]           place,
	input  logic [POS_W-1:0]     position,
	input  logic [IO_DATA_W-1:0] data_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [IO_DATA_W-1:0] read_data,
	output logic [POS_W-1:0]     entry_count,
	output logic                 is_empty
);

	// Count width holds DEPTH itself; positions are compared at the wider
	// of the count width and the port width.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int XW   = (CW > POS_W) ? CW : POS_W;
	// Registered stages of the read chain, and the counter that waits them out.
	localparam int NSTG = (DEPTH + READ_GROUP - 1) / READ_GROUP;
	localparam int RCW  = $clog2(NSTG + 1);

	localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
	localparam logic [RCW-1:0] NSTG_C  = RCW'(NSTG);

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [XW-1:0]         rd_pos_q;
	logic [RCW-1:0]        rcnt_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IO_DATA_W-1:0]  out_data_q;
	logic [POS_W-1:0]      out_count_q;
	logic                  out_empty_q;

	logic                  out_free;
	logic                  acc;
	op_t                   op_e;
	logic                  place_ok;
	logic [XW-1:0]         pos_res;
	logic [XW-1:0]         cnt_x;
	logic                  cmd_ok;
	status_t               cmd_status;
	logic                  start_read;
	logic                  load;
	status_t               load_status;
	logic [IO_DATA_W-1:0]  load_data;
	cell_ctrl_t            cell_ctrl;
	logic [XW-1:0]         cell_pos;
	logic [DATA_WIDTH-1:0] din_w;
	logic [DATA_WIDTH-1:0] chain_rd;
	logic [WIDE_W-1:0]     rd_wide;

	// The output register can take a result when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign acc      = in_valid && !in_stall;
	assign op_e     = op_t'(op);
	assign cnt_x    = XW'(count_q);

	// Store words at DATA_WIDTH bits: zero-extend the port word, then trim.
	assign din_w   = DATA_WIDTH'(WIDE_W'(data_in));
	assign rd_wide = WIDE_W'(chain_rd);

	// Target position. Back means count for an insert and count-1 otherwise;
	// the unused place code is flagged and fails every request but a clear.
	always_comb begin
		place_ok = 1'b1;
		pos_res  = '0;
		unique case (place)
			PLACE_POS: begin
				pos_res = XW'(position);
			end
			PLACE_FRONT: begin
				pos_res = '0;
			end
			PLACE_BACK: begin
				pos_res = (op_e == OP_INSERT) ? cnt_x : (cnt_x - 1'b1);
			end
			default: begin
				place_ok = 1'b0;
			end
		endcase
	end

	// Status of the request and the count it leaves behind.
	always_comb begin
		cmd_ok     = 1'b0;
		cmd_status = ST_OK;
		count_d    = count_q;
		unique case (op_e)
			OP_INSERT: begin
				if (count_q == DEPTH_C) begin
					cmd_status = ST_FULL;
				end else if (!place_ok || (pos_res > cnt_x)) begin
					cmd_status = ST_RANGE;
				end else begin
					cmd_ok  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_REMOVE, OP_READ: begin
				if ((count_q == '0) || !place_ok || (pos_res >= cnt_x)) begin
					cmd_status = ST_RANGE;
				end else begin
					cmd_ok = 1'b1;
					if (op_e == OP_REMOVE) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				if (count_q == '0) begin
					cmd_status = ST_RANGE;
				end else begin
					cmd_ok  = 1'b1;
					count_d = '0;
				end
			end
		endcase
	end

	assign cell_ctrl.ins = acc && cmd_ok && (op_e == OP_INSERT);
	assign cell_ctrl.rem = acc && cmd_ok && (op_e == OP_REMOVE);
	// While a read runs the chain looks at the captured position.
	assign cell_pos      = (state_q == S_READ) ? rd_pos_q : pos_res;

	ple_chain #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.XW         (XW)
	) u_chain (
		.clk     (clk),
		.ctrl    (cell_ctrl),
		.pos     (cell_pos),
		.din     (din_w),
		.rd_data (chain_rd)
	);

	// Controller: next state and output loading. A successful read parks in
	// S_READ until the chain has settled and the output register is free.
	always_comb begin
		state_d     = state_q;
		start_read  = 1'b0;
		load        = 1'b0;
		load_status = ST_OK;
		load_data   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (cmd_ok && (op_e == OP_READ)) begin
						start_read = 1'b1;
						state_d    = S_READ;
					end else begin
						load        = 1'b1;
						load_status = cmd_status;
					end
				end
			end
			S_READ: begin
				if ((rcnt_q == NSTG_C) && out_free) begin
					load      = 1'b1;
					load_data = rd_wide[IO_DATA_W-1:0];
					state_d   = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				count_q <= count_d;
			end
			if (start_read) begin
				rcnt_q <= '0;
			end else if ((state_q == S_READ) && (rcnt_q != NSTG_C)) begin
				rcnt_q <= rcnt_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (start_read) begin
			rd_pos_q <= pos_res;
		end
		if (load) begin
			out_status_q <= load_status;
			out_data_q   <= load_data;
			if (state_q == S_READ) begin
				out_count_q <= POS_W'(count_q);
				out_empty_q <= (count_q == '0);
			end else begin
				out_count_q <= POS_W'(count_d);
				out_empty_q <= (count_d == '0);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign read_data   = out_data_q;
	assign entry_count = out_count_q;
	assign is_empty    = out_empty_q;

	`PLE_ASSERT_NEXT(a_insert_grows, cell_ctrl.ins, count_q == ($past(count_q) + 1'b1), "insert did not grow the count by one")
	`PLE_ASSERT_NEXT(a_read_keeps_count, state_q == S_READ, $stable(count_q), "count changed while a read was running")
	`PLE_ASSERT(a_fail_no_data, (out_valid && (status != ST_OK)) |-> (read_data == '0), "failed request returned nonzero read data")

endmodule

// ===== bench/positional_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts the answer to every accepted request, and each answer that
// leaves the block is compared field by field with the oldest prediction.
// A short directed sequence covers empty, edge and bad-position requests,
// then random traffic alternates between filling, draining and mixed phases
// with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
	import ple_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 500;
	// Place code with no meaning; the block must reject it.
	localparam logic [1:0] PLACE_UNUSED = 2'd3;
	// Cycles to watch after the last awaited answer, long enough for a
	// stray extra answer to show, even one from a successful read.
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		TRAFFIC_GROW,
		TRAFFIC_SHRINK,
		TRAFFIC_MIX
	} traffic_t;

	// One predicted answer of the block.
	typedef struct {
		status_t              status;
		logic [IO_DATA_W-1:0] read_data;
		logic [POS_W-1:0]     entry_count;
		logic                 is_empty;
	} answer_t;

	// ------------------------------------------------------------------------
	// Shadow list and answer scoreboard.
	// ------------------------------------------------------------------------
	class list_shadow;
		logic [IO_DATA_W-1:0] slots [LIST_DEPTH];
		int unsigned          count;
		answer_t              awaited [$];
		int                   errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Update the shadow list with an accepted request and queue its answer.
		function void apply_request(op_t cmd, logic [1:0] where, logic [POS_W-1:0] pos,
			logic [IO_DATA_W-1:0] word);
			answer_t     ans;
			int unsigned target;
			int unsigned back;
			bit          known_place;

			ans.status    = ST_OK;
			ans.read_data = '0;
			back          = (cmd == OP_INSERT) ? count : count - 1;
			known_place   = 1'b1;
			case (where)
				PLACE_POS:   target = pos;
				PLACE_FRONT: target = 0;
				PLACE_BACK:  target = back;
				default: begin
					target      = 0;
					known_place = 1'b0;
				end
			endcase

			case (cmd)
				OP_INSERT: begin
					if (count >= LIST_DEPTH) begin
						ans.status = ST_FULL;
					end else if (!known_place || target > count) begin
						ans.status = ST_RANGE;
					end else begin
						for (int i = count; i > target; i--)
							slots[i] = slots[i-1];
						slots[target] = word;
						count++;
					end
				end
				OP_REMOVE, OP_READ: begin
					if (count == 0 || !known_place || target >= count) begin
						ans.status = ST_RANGE;
					end else if (cmd == OP_READ) begin
						ans.read_data = slots[target];
					end else begin
						for (int i = target; i + 1 < count; i++)
							slots[i] = slots[i+1];
						count--;
					end
				end
				default: begin
					if (count == 0)
						ans.status = ST_RANGE;
					else
						count = 0;
				end
			endcase

			ans.entry_count = POS_W'(count);
			ans.is_empty    = (count == 0);
			awaited.push_back(ans);
		endfunction

		function void compare_field(string field, logic [IO_DATA_W-1:0] want,
			logic [IO_DATA_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		// Check one answer taken from the block against the oldest prediction.
		function void check_answer(logic [1:0] st, logic [IO_DATA_W-1:0] rd,
			logic [POS_W-1:0] cnt, logic empty);
			answer_t ans;

			if (awaited.size() == 0) begin
				$display("%0t: unexpected answer, expected none, actual status %0h count %0h",
					$time, st, cnt);
				errors++;
				return;
			end
			ans = awaited.pop_front();
			compare_field("status", IO_DATA_W'(ans.status), IO_DATA_W'(st));
			compare_field("read_data", ans.read_data, rd);
			compare_field("entry_count", IO_DATA_W'(ans.entry_count), IO_DATA_W'(cnt));
			compare_field("is_empty", IO_DATA_W'(ans.is_empty), IO_DATA_W'(empty));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test.
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           op;
	logic [1:0]           place;
	logic [POS_W-1:0]     position;
	logic [IO_DATA_W-1:0] data_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic [IO_DATA_W-1:0] read_data;
	logic [POS_W-1:0]     entry_count;
	logic                 is_empty;

	// When set, neither side idles, so requests and answers run back to back except while in_stall is high.
	bit no_idle;

	list_shadow shadow;

	positional_list_engine_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.place       (place),
		.position    (position),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_data   (read_data),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit. The slowest correct run is around 585 requests, each with
	// idle cycles before it, a read through the chain and stalled cycles on
	// the answer side; this allows more than ten times as long as that run.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request side. Inputs change only at the rising edge, after the block
	// has sampled them, and a request holds still until it is accepted.
	// ------------------------------------------------------------------------
	task automatic send_request(input op_t cmd, input logic [1:0] where,
		input logic [POS_W-1:0] pos, input logic [IO_DATA_W-1:0] word);
		int gap;

		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= cmd;
		place    <= where;
		position <= pos;
		data_in  <= word;
		// The values seen right after the edge are the ones the block saw.
		do @(posedge clk); while (in_stall);
		shadow.apply_request(cmd, where, pos, word);
	endtask

	// One random request shaped by the traffic phase. Most positions are
	// legal for the current list length so that the shifts get exercised;
	// the rest span the whole field to hit the range checks.
	task automatic send_random(input traffic_t traffic);
		int               roll;
		op_t              cmd;
		logic [1:0]       where;
		logic [POS_W-1:0] pos;
		int unsigned      top;

		roll = $urandom_range(0, 99);
		case (traffic)
			TRAFFIC_GROW:
				cmd = (roll < 85) ? OP_INSERT : (roll < 95) ? OP_READ : OP_REMOVE;
			TRAFFIC_SHRINK:
				cmd = (roll < 15) ? OP_INSERT : (roll < 70) ? OP_REMOVE : OP_READ;
			default:
				cmd = (roll < 35) ? OP_INSERT : (roll < 60) ? OP_REMOVE :
					(roll < 97) ? OP_READ : OP_CLEAR;
		endcase

		roll  = $urandom_range(0, 99);
		where = (roll < 70) ? PLACE_POS : (roll < 82) ? PLACE_FRONT :
			(roll < 94) ? PLACE_BACK : PLACE_UNUSED;

		if (cmd == OP_INSERT)
			top = shadow.count;
		else
			top = (shadow.count > 0) ? shadow.count - 1 : 0;
		if ($urandom_range(0, 99) < 85)
			pos = POS_W'($urandom_range(0, top));
		else
			pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));

		send_request(cmd, where, pos, $urandom());
	endtask

	// ------------------------------------------------------------------------
	// Answer side. Each answer draws a number of stalled cycles first, then
	// the answer is taken at the first edge with out_valid high and
	// out_stall low.
	// ------------------------------------------------------------------------
	initial begin : answer_side
		int hold;

		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			shadow.check_answer(status, read_data, entry_count, is_empty);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		int       sent;
		int       span;
		int       roll;
		traffic_t traffic;

		shadow   = new();
		no_idle  = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		op       = OP_READ;
		place    = PLACE_POS;
		position = '0;
		data_in  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every request on an empty list fails, clear included, and an
		// insert beyond the end is refused.
		send_request(OP_READ,   PLACE_FRONT, 7'd0, 32'h0);
		send_request(OP_REMOVE, PLACE_BACK,  7'd0, 32'h0);
		send_request(OP_CLEAR,  PLACE_POS,   7'd0, 32'h0);
		send_request(OP_INSERT, PLACE_POS,   7'd1, 32'h1111_1111);

		// Build a five-entry list through every kind of place: at position,
		// front, back, the middle and exactly at the end.
		send_request(OP_INSERT, PLACE_POS,   7'd0, 32'hFFFF_FFFF);
		send_request(OP_INSERT, PLACE_FRONT, 7'd0, 32'h0000_0000);
		send_request(OP_INSERT, PLACE_BACK,  7'd0, 32'hA5A5_A5A5);
		send_request(OP_INSERT, PLACE_POS,   7'd1, 32'h5A5A_5A5A);
		send_request(OP_INSERT, PLACE_POS,   7'd4, 32'h1234_5678);
		send_request(OP_INSERT, PLACE_UNUSED, 7'd0, 32'hDEAD_BEEF);
		send_request(OP_INSERT, PLACE_POS,   7'd127, 32'hDEAD_BEEF);

		// Reads at positions 0, 2 and 4, one past the end, the largest
		// position, front, back and the unused place code.
		send_request(OP_READ, PLACE_POS,    7'd0, 32'h0);
		send_request(OP_READ, PLACE_POS,    7'd2, 32'h0);
		send_request(OP_READ, PLACE_POS,    7'd4, 32'h0);
		send_request(OP_READ, PLACE_POS,    7'd5, 32'h0);
		send_request(OP_READ, PLACE_POS,    7'd127, 32'h0);
		send_request(OP_READ, PLACE_FRONT,  7'd0, 32'h0);
		send_request(OP_READ, PLACE_BACK,   7'd0, 32'h0);
		send_request(OP_READ, PLACE_UNUSED, 7'd0, 32'h0);

		// Removes: rejected ones first, then the middle, front and back.
		send_request(OP_REMOVE, PLACE_UNUSED, 7'd0, 32'h0);
		send_request(OP_REMOVE, PLACE_POS,    7'd127, 32'h0);
		send_request(OP_REMOVE, PLACE_POS,    7'd2, 32'h0);
		send_request(OP_REMOVE, PLACE_FRONT,  7'd0, 32'h0);
		send_request(OP_REMOVE, PLACE_BACK,   7'd0, 32'h0);
		send_request(OP_CLEAR,  PLACE_UNUSED, 7'd0, 32'h0);

		// Random traffic in phases. Growth phases are the most common so
		// the list regularly reaches full and inserts get refused there.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			roll    = $urandom_range(0, 99);
			traffic = (roll < 40) ? TRAFFIC_GROW :
				(roll < 70) ? TRAFFIC_SHRINK : TRAFFIC_MIX;
			no_idle = ($urandom_range(0, 3) == 0);
			span    = $urandom_range(20, 60);
			repeat (span) send_random(traffic);
			sent += span;
		end
		no_idle  = 1'b0;
		in_valid <= 1'b0;

		// Wait for every predicted answer, then watch a little longer so a
		// stray extra answer is caught.
		while (shadow.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_chain.sv
rtl/core/positional_list_engine_core.sv
bench/positional_list_engine_core_tb.sv
